// ===== sv/pcie_lt_pkg.sv =====
`default_nettype none
package pcie_lt_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CNT_OUT_WIDTH = 16;

   // event kinds
   localparam logic [4:0] EV_TRAIN   = 5'd0;
   localparam logic [4:0] EV_LINKSET = 5'd1;
   localparam logic [4:0] EV_SETRATE = 5'd2;
   localparam logic [4:0] EV_SWITCH  = 5'd3;
   localparam logic [4:0] EV_L0S     = 5'd4;
   localparam logic [4:0] EV_L1      = 5'd5;
   localparam logic [4:0] EV_L2      = 5'd6;
   localparam logic [4:0] EV_EXITLP  = 5'd7;
   localparam logic [4:0] EV_EQSTART = 5'd8;
   localparam logic [4:0] EV_PRESET  = 5'd9;
   localparam logic [4:0] EV_TS1     = 5'd10;
   localparam logic [4:0] EV_TS2     = 5'd11;
   localparam logic [4:0] EV_EQADV   = 5'd12;
   localparam logic [4:0] EV_PRSNT   = 5'd13;
   localparam logic [4:0] EV_MRL     = 5'd14;
   localparam logic [4:0] EV_PWRGOOD = 5'd15;
   localparam logic [4:0] EV_REFCLK  = 5'd16;
   localparam logic [4:0] EV_PERST   = 5'd17;
   localparam logic [4:0] EV_TICK    = 5'd18;

   // link states
   localparam logic [2:0] ST_DETECT   = 3'd0;
   localparam logic [2:0] ST_L0       = 3'd1;
   localparam logic [2:0] ST_RECOVERY = 3'd2;
   localparam logic [2:0] ST_L0S      = 3'd3;
   localparam logic [2:0] ST_L1       = 3'd4;
   localparam logic [2:0] ST_L2       = 3'd5;

   // equalization stages
   localparam logic [2:0] EQ_IDLE = 3'd0;
   localparam logic [2:0] EQ_TS1  = 3'd1;
   localparam logic [2:0] EQ_TS2  = 3'd2;
   localparam logic [2:0] EQ_PH2  = 3'd3;
   localparam logic [2:0] EQ_PH3  = 3'd4;
   localparam logic [2:0] EQ_DONE = 3'd5;

   localparam logic [3:0] MAX_PRESET = 4'd7;

   typedef struct packed {
      logic [6:0] pad;
      logic       switch_ready;
      logic [3:0] preset_value;
      logic [2:0] rate_code;
      logic       level;
   } req_word_type;

   typedef struct packed {
      logic [5:0]               pad;
      logic                     switch_complete;
      logic                     switch_request;
      logic [CNT_OUT_WIDTH-1:0] insertions;
      logic [CNT_OUT_WIDTH-1:0] removals;
      logic                     switch_pending;
      logic [2:0]               rate_now;
      logic [2:0]               eq_preset_now;
      logic [2:0]               eq_stage;
      logic                     eq_active;
      logic                     is_initialized;
      logic                     link_is_up;
      logic [2:0]               link_state;
   } rsp_word_type;

endpackage
`default_nettype wire

// ===== sv/pcie_link_training_controller.sv =====
// Simplified PCIe link state controller. Each event word on the req_ channel
// (kind in tuser) updates the link, equalization, rate-switch and hot-plug
// state and produces exactly one status word on the rsp_ channel, registered
// and valid in the cycle after the event is taken. A new event is taken every
// cycle while the output is empty or being drained, so throughput is one word
// per clock. csr_wdata sets link_layer_present: when 1 a rate switch waits for
// a tick with switch_ready, when 0 it completes at once. Write the CSR only
// while no event is outstanding.
`default_nettype none
module pcie_link_training_controller (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // level, rate_code[3:1], preset_value[7:4], switch_ready[8], zero pad
   input  wire logic [15:0]               req_tdata,
   // kind
   input  wire logic [4:0]                req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // link_state, link_is_up, is_initialized, eq_active, eq_stage, eq_preset_now,
   // rate_now, switch_pending, removals, insertions, switch_request,
   // switch_complete, zero pad
   output logic [55:0]                    rsp_tdata,
   input  wire logic                      csr_we,
   input  wire logic                      csr_wdata
);
   import pcie_lt_pkg::*;

   req_word_type req_word;
   rsp_word_type rsp_in, rsp_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   logic llp_ff;
   logic [2:0] state_ff, state_in;
   logic up_ff, up_in, init_ff, init_in, eq_ff, eq_in;
   logic [2:0] phase_ff, phase_in, preset_ff, preset_in, rate_ff, rate_in;
   logic sw_ff, sw_in;
   logic [2:0] target_ff, target_in;
   logic prsnt_ff, prsnt_in, mrl_ff, mrl_in, pwr_ff, pwr_in, ref_ff, ref_in;
   logic perst_ff, perst_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in, ins_ff, ins_in;
   logic sw_req, sw_done;

   assign req_word   = req_word_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_comb begin
      state_in  = state_ff;
      up_in     = up_ff;
      init_in   = init_ff;
      eq_in     = eq_ff;
      phase_in  = phase_ff;
      preset_in = preset_ff;
      rate_in   = rate_ff;
      sw_in     = sw_ff;
      target_in = target_ff;
      prsnt_in  = prsnt_ff;
      mrl_in    = mrl_ff;
      pwr_in    = pwr_ff;
      ref_in    = ref_ff;
      perst_in  = perst_ff;
      rem_in    = rem_ff;
      ins_in    = ins_ff;
      sw_req    = 1'b0;
      sw_done   = 1'b0;
      case (req_tuser)
         EV_TRAIN: begin
            state_in = ST_L0;
            up_in    = 1'b1;
            init_in  = 1'b1;
         end
         EV_LINKSET: begin
            up_in   = req_word.level;
            init_in = 1'b1;
            if (!req_word.level) begin
               state_in = ST_DETECT;
               eq_in    = 1'b0;
               phase_in = EQ_IDLE;
            end
         end
         EV_SETRATE: rate_in = req_word.rate_code;
         EV_SWITCH: begin
            if (req_word.rate_code != rate_ff) begin
               target_in = req_word.rate_code;
               if (llp_ff) begin
                  sw_in    = 1'b1;
                  state_in = ST_RECOVERY;
                  up_in    = 1'b0;
                  sw_req   = 1'b1;
               end else begin
                  sw_in    = 1'b0;
                  state_in = ST_L0;
                  rate_in  = req_word.rate_code;
                  up_in    = 1'b1;
               end
            end
         end
         EV_L0S: begin
            state_in = ST_L0S;
            up_in    = 1'b0;
         end
         EV_L1: begin
            state_in = ST_L1;
            up_in    = 1'b0;
         end
         EV_L2: begin
            state_in = ST_L2;
            up_in    = 1'b0;
         end
         EV_EXITLP: begin
            if (state_ff inside {ST_L0S, ST_L1}) begin
               state_in = ST_L0;
               up_in    = 1'b1;
            end
         end
         EV_EQSTART: begin
            eq_in     = 1'b1;
            phase_in  = EQ_TS1;
            preset_in = '0;
         end
         EV_PRESET: begin
            if (req_word.preset_value <= MAX_PRESET) begin
               preset_in = req_word.preset_value[2:0];
            end
         end
         EV_TS1: begin
            if (phase_ff == EQ_IDLE) begin
               phase_in = EQ_TS1;
            end
            eq_in = 1'b1;
         end
         EV_TS2: begin
            if (phase_ff != EQ_DONE) begin
               phase_in = EQ_TS2;
            end
         end
         EV_EQADV: begin
            if (phase_ff inside {[EQ_TS1:EQ_PH2]}) begin
               phase_in = phase_ff + 3'd1;
            end else if (phase_ff == EQ_PH3) begin
               phase_in = EQ_DONE;
               eq_in    = 1'b0;
            end
         end
         EV_PRSNT: begin
            if (prsnt_ff && !req_word.level) begin
               // surprise removal
               rem_in   = rem_ff + COUNT_WIDTH'(1);
               state_in = ST_DETECT;
               up_in    = 1'b0;
               eq_in    = 1'b0;
               phase_in = EQ_IDLE;
            end else if (!prsnt_ff && req_word.level) begin
               ins_in = ins_ff + COUNT_WIDTH'(1);
            end
            prsnt_in = req_word.level;
         end
         EV_MRL:     mrl_in = req_word.level;
         EV_PWRGOOD: pwr_in = req_word.level;
         EV_REFCLK:  ref_in = req_word.level;
         EV_PERST: begin
            perst_in = req_word.level;
            if (req_word.level) begin
               state_in = ST_DETECT;
               up_in    = 1'b0;
               eq_in    = 1'b0;
               phase_in = EQ_IDLE;
            end else if (prsnt_ff && mrl_ff && pwr_ff && ref_ff) begin
               state_in = ST_L0;
               up_in    = 1'b1;
            end
         end
         EV_TICK: begin
            if (sw_ff && (req_word.switch_ready || !llp_ff)) begin
               sw_in    = 1'b0;
               rate_in  = target_ff;
               state_in = ST_L0;
               up_in    = 1'b1;
               sw_done  = llp_ff;
            end
         end
         default: ;
      endcase

      rsp_in                 = '0;
      rsp_in.link_state      = state_in;
      rsp_in.link_is_up      = up_in;
      rsp_in.is_initialized  = init_in;
      rsp_in.eq_active       = eq_in;
      rsp_in.eq_stage        = phase_in;
      rsp_in.eq_preset_now   = preset_in;
      rsp_in.rate_now        = rate_in;
      rsp_in.switch_pending  = sw_in;
      rsp_in.removals        = CNT_OUT_WIDTH'(rem_in);
      rsp_in.insertions      = CNT_OUT_WIDTH'(ins_in);
      rsp_in.switch_request  = sw_req;
      rsp_in.switch_complete = sw_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         llp_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_DETECT;
         up_ff        <= 1'b0;
         init_ff      <= 1'b0;
         eq_ff        <= 1'b0;
         phase_ff     <= EQ_IDLE;
         preset_ff    <= '0;
         rate_ff      <= '0;
         sw_ff        <= 1'b0;
         target_ff    <= '0;
         prsnt_ff     <= 1'b0;
         mrl_ff       <= 1'b0;
         pwr_ff       <= 1'b0;
         ref_ff       <= 1'b0;
         perst_ff     <= 1'b0;
         rem_ff       <= '0;
         ins_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            llp_ff <= csr_wdata;
         end
         if (accept) begin
            state_ff  <= state_in;
            up_ff     <= up_in;
            init_ff   <= init_in;
            eq_ff     <= eq_in;
            phase_ff  <= phase_in;
            preset_ff <= preset_in;
            rate_ff   <= rate_in;
            sw_ff     <= sw_in;
            target_ff <= target_in;
            prsnt_ff  <= prsnt_in;
            mrl_ff    <= mrl_in;
            pwr_ff    <= pwr_in;
            ref_ff    <= ref_in;
            perst_ff  <= perst_in;
            rem_ff    <= rem_in;
            ins_ff    <= ins_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/pcie_lt_checker.sv =====
`default_nettype none
module pcie_lt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);
   import pcie_lt_pkg::*;

   rsp_word_type rsp_word;
   assign rsp_word = rsp_word_type'(rsp_tdata);

   // a held status word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // an empty output stage always takes a new event
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   a_req_recovery: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_word.switch_request |->
         rsp_word.switch_pending && rsp_word.link_state == ST_RECOVERY &&
         !rsp_word.link_is_up)
      else $error("switch request without pending switch in recovery");

   a_done_l0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_word.switch_complete |->
         !rsp_word.switch_pending && !rsp_word.switch_request &&
         rsp_word.link_state == ST_L0 && rsp_word.link_is_up)
      else $error("switch complete without link back in L0");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

endmodule

bind pcie_link_training_controller pcie_lt_checker u_pcie_lt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== tb/tb_pcie_link_training_controller.sv =====
module tb_pcie_link_training_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import pcie_lt_pkg::*;

   typedef struct {
      logic [4:0]   kind;
      req_word_type word;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [4:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;

   pcie_link_training_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the link controller
   logic                   cfg_llp;
   logic [2:0]             m_state, m_stage, m_preset, m_rate, m_target;
   logic                   m_up, m_init, m_eq, m_switching;
   logic                   lv_present, lv_mrl, lv_pwrgood, lv_refclk, lv_perst;
   logic [COUNT_WIDTH-1:0] m_removals, m_insertions;

   req_item_type pending_events[$];
   rsp_word_type status_queue[$];

   int unsigned items_queued = 0;
   int unsigned items_accepted = 0;
   int unsigned words_checked = 0;
   int unsigned err_count = 0;
   int unsigned n_requests = 0;
   int unsigned n_completes = 0;
   int unsigned cycle_count = 0;
   bit          req_taken = 1'b0;
   bit          quiet_window;
   int unsigned rsp_hold_left = 0;
   bit          stall_done = 1'b0;

   assign quiet_window = (cycle_count >= 800) && (cycle_count < 1300);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tb_pcie_link_training_controller: done, errors");
      $finish;
   end

   function automatic void drop_to_detect();
      m_state = ST_DETECT;
      m_up    = 1'b0;
      m_eq    = 1'b0;
      m_stage = EQ_IDLE;
   endfunction

   task automatic link_status_after(input logic [4:0] kind, input req_word_type w,
                                    output rsp_word_type s);
      logic req_pulse, done_pulse;
      req_pulse  = 1'b0;
      done_pulse = 1'b0;
      case (kind)
         EV_TRAIN: begin
            m_state = ST_L0; m_up = 1'b1; m_init = 1'b1;
         end
         EV_LINKSET: begin
            m_up = w.level; m_init = 1'b1;
            if (!w.level) drop_to_detect();
         end
         EV_SETRATE: m_rate = w.rate_code;
         EV_SWITCH: begin
            if (w.rate_code != m_rate) begin
               m_target = w.rate_code;
               if (cfg_llp) begin
                  m_switching = 1'b1;
                  m_state     = ST_RECOVERY;
                  m_up        = 1'b0;
                  req_pulse   = 1'b1;
               end else begin
                  m_switching = 1'b0;
                  m_state     = ST_L0;
                  m_rate      = w.rate_code;
                  m_up        = 1'b1;
               end
            end
         end
         EV_L0S: begin m_state = ST_L0S; m_up = 1'b0; end
         EV_L1:  begin m_state = ST_L1;  m_up = 1'b0; end
         EV_L2:  begin m_state = ST_L2;  m_up = 1'b0; end
         EV_EXITLP: begin
            if (m_state == ST_L0S || m_state == ST_L1) begin
               m_state = ST_L0; m_up = 1'b1;
            end
         end
         EV_EQSTART: begin
            m_eq = 1'b1; m_stage = EQ_TS1; m_preset = '0;
         end
         EV_PRESET: if (w.preset_value <= MAX_PRESET) m_preset = w.preset_value[2:0];
         EV_TS1: begin
            if (m_stage == EQ_IDLE) m_stage = EQ_TS1;
            m_eq = 1'b1;
         end
         EV_TS2: if (m_stage != EQ_DONE) m_stage = EQ_TS2;
         EV_EQADV: begin
            if (m_stage >= EQ_TS1 && m_stage <= EQ_PH2) begin
               m_stage = m_stage + 3'd1;
            end else if (m_stage == EQ_PH3) begin
               m_stage = EQ_DONE; m_eq = 1'b0;
            end
         end
         EV_PRSNT: begin
            if (lv_present && !w.level) begin
               m_removals = m_removals + COUNT_WIDTH'(1);
               drop_to_detect();
            end else if (!lv_present && w.level) begin
               m_insertions = m_insertions + COUNT_WIDTH'(1);
            end
            lv_present = w.level;
         end
         EV_MRL:     lv_mrl = w.level;
         EV_PWRGOOD: lv_pwrgood = w.level;
         EV_REFCLK:  lv_refclk = w.level;
         EV_PERST: begin
            lv_perst = w.level;
            if (w.level) begin
               drop_to_detect();
            end else if (lv_present && lv_mrl && lv_pwrgood && lv_refclk) begin
               m_state = ST_L0; m_up = 1'b1;
            end
         end
         EV_TICK: begin
            if (m_switching && (w.switch_ready || !cfg_llp)) begin
               m_switching = 1'b0;
               m_rate      = m_target;
               m_state     = ST_L0;
               m_up        = 1'b1;
               done_pulse  = cfg_llp;
            end
         end
         default: ;
      endcase
      s                 = '0;
      s.link_state      = m_state;
      s.link_is_up      = m_up;
      s.is_initialized  = m_init;
      s.eq_active       = m_eq;
      s.eq_stage        = m_stage;
      s.eq_preset_now   = m_preset;
      s.rate_now        = m_rate;
      s.switch_pending  = m_switching;
      s.removals        = m_removals[CNT_OUT_WIDTH-1:0];
      s.insertions      = m_insertions[CNT_OUT_WIDTH-1:0];
      s.switch_request  = req_pulse;
      s.switch_complete = done_pulse;
   endtask

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   // handshake bookkeeping, prediction and checking
   always @(posedge clock) begin : mon
      rsp_word_type want, got;
      cycle_count++;
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         link_status_after(req_tuser, req_word_type'(req_tdata), want);
         status_queue.push_back(want);
         items_accepted++;
         n_requests  += want.switch_request;
         n_completes += want.switch_complete;
         req_taken = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_word_type'(rsp_tdata);
         if (status_queue.size() == 0) begin
            $error("status word with nothing outstanding: %h", rsp_tdata);
            err_count++;
         end else begin
            want = status_queue.pop_front();
            words_checked++;
            check_field("link_state", want.link_state, got.link_state);
            check_field("link_is_up", want.link_is_up, got.link_is_up);
            check_field("is_initialized", want.is_initialized, got.is_initialized);
            check_field("eq_active", want.eq_active, got.eq_active);
            check_field("eq_stage", want.eq_stage, got.eq_stage);
            check_field("eq_preset_now", want.eq_preset_now, got.eq_preset_now);
            check_field("rate_now", want.rate_now, got.rate_now);
            check_field("switch_pending", want.switch_pending, got.switch_pending);
            check_field("removals", want.removals, got.removals);
            check_field("insertions", want.insertions, got.insertions);
            check_field("switch_request", want.switch_request, got.switch_request);
            check_field("switch_complete", want.switch_complete, got.switch_complete);
            check_field("pad", want.pad, got.pad);
         end
      end
   end

   always @(negedge clock) begin : drive_req
      req_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_events.size() != 0 && (quiet_window || $urandom_range(99) >= 10)) begin
            it = pending_events.pop_front();
            req_tdata  <= it.word;
            req_tuser  <= it.kind;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // one long hold-off mid-run so the output backs up into the input
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready    <= 1'b0;
      end else if (!stall_done && items_accepted >= 700) begin
         stall_done    <= 1'b1;
         rsp_hold_left <= 150;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= quiet_window || ($urandom_range(99) >= 10);
      end
   end

   task automatic queue_event(input logic [4:0] kind, input logic level = 1'b0,
                              input logic [2:0] rate = '0, input logic [3:0] preset = '0,
                              input logic ready = 1'b0);
      req_item_type it;
      it.kind = kind;
      it.word = '0;
      it.word.level = level;
      it.word.rate_code = rate;
      it.word.preset_value = preset;
      it.word.switch_ready = ready;
      pending_events.push_back(it);
      items_queued++;
   endtask

   function automatic logic mostly_one();
      return $urandom_range(9) != 0;
   endfunction

   task automatic queue_random_items(input int unsigned count);
      int unsigned stop_at, n;
      logic [4:0] k;
      stop_at = items_queued + count;
      while (items_queued < stop_at) begin
         case ($urandom_range(9))
            0, 1: begin
               // training and equalization
               queue_event(EV_TRAIN, $urandom_range(1), $urandom_range(7));
               queue_event(EV_EQSTART, $urandom_range(1));
               n = $urandom_range(1, 5);
               repeat (n) begin
                  case ($urandom_range(3))
                     0: queue_event(EV_PRESET, $urandom_range(1), $urandom_range(7),
                                    $urandom_range(15));
                     1: queue_event(EV_TS1, $urandom_range(1));
                     2: queue_event(EV_TS2, $urandom_range(1));
                     default: queue_event(EV_EQADV, $urandom_range(1));
                  endcase
               end
               n = $urandom_range(4);
               repeat (n) queue_event(EV_EQADV, $urandom_range(1), $urandom_range(7));
            end
            2, 3: begin
               // rate change, with ticks that may or may not report ready
               if ($urandom_range(2) == 0)
                  queue_event(EV_SETRATE, $urandom_range(1), $urandom_range(7));
               queue_event(EV_SWITCH, $urandom_range(1), $urandom_range(7),
                           $urandom_range(15), $urandom_range(1));
               n = $urandom_range(3);
               repeat (n) queue_event(EV_TICK, $urandom_range(1), $urandom_range(7),
                                      $urandom_range(15), 1'b0);
               if ($urandom_range(3) == 0)
                  queue_event(EV_SWITCH, $urandom_range(1), $urandom_range(7));
               queue_event(EV_TICK, $urandom_range(1), $urandom_range(7),
                           $urandom_range(15), mostly_one());
            end
            4, 5: begin
               // hot-plug bring-up, sometimes a surprise removal
               queue_event(EV_PRSNT, mostly_one());
               queue_event(EV_MRL, mostly_one());
               queue_event(EV_PWRGOOD, mostly_one());
               queue_event(EV_REFCLK, mostly_one());
               queue_event(EV_PERST, 1'b1);
               queue_event(EV_PERST, !mostly_one());
               if ($urandom_range(2) == 0) queue_event(EV_PRSNT, 1'b0);
            end
            6: begin
               k = EV_L0S + 5'($urandom_range(2));
               queue_event(k, $urandom_range(1));
               if ($urandom_range(1)) queue_event(EV_TICK, 1'b0, '0, '0, $urandom_range(1));
               queue_event(EV_EXITLP, $urandom_range(1));
               if (k == EV_L2) begin
                  if ($urandom_range(1)) queue_event(EV_PERST, 1'b0);
                  else queue_event(EV_LINKSET, 1'b1);
               end
            end
            7: queue_event(EV_LINKSET, $urandom_range(1), $urandom_range(7));
            default: begin
               n = $urandom_range(1, 4);
               repeat (n) queue_event($urandom_range(31), $urandom_range(1),
                                      $urandom_range(7), $urandom_range(15),
                                      $urandom_range(1));
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (items_accepted != items_queued || status_queue.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_llp(input logic v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      cfg_llp = v;
   endtask

   initial begin
      cfg_llp = 1'b1;
      m_state = ST_DETECT; m_stage = EQ_IDLE; m_preset = '0; m_rate = '0; m_target = '0;
      m_up = 1'b0; m_init = 1'b0; m_eq = 1'b0; m_switching = 1'b0;
      lv_present = 1'b0; lv_mrl = 1'b0; lv_pwrgood = 1'b0; lv_refclk = 1'b0;
      lv_perst = 1'b0;
      m_removals = '0; m_insertions = '0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      write_llp(1'b1);

      @(posedge clock);
      queue_event(5'd31, 1'b1, 3'd7, 4'd15, 1'b1);   // unknown kind, status unchanged
      queue_event(EV_PRSNT, 1'b1);
      queue_event(EV_MRL, 1'b1);
      queue_event(EV_PWRGOOD, 1'b1);
      queue_event(EV_REFCLK, 1'b1);
      queue_event(EV_PERST, 1'b1);
      queue_event(EV_PERST, 1'b0);                    // all levels good: back to L0
      queue_event(EV_TRAIN);
      queue_event(EV_SETRATE, 1'b0, 3'd7);
      queue_event(EV_SWITCH, 1'b0, 3'd7);             // same rate: ignored
      queue_event(EV_SWITCH, 1'b0, 3'd0);
      queue_event(EV_SWITCH, 1'b1, 3'd5);             // retarget while pending
      queue_event(EV_TICK, 1'b0, '0, '0, 1'b0);
      queue_event(EV_TICK, 1'b0, '0, '0, 1'b1);
      queue_event(EV_L0S);
      queue_event(EV_EXITLP);
      queue_event(EV_L1);
      queue_event(EV_L2);
      queue_event(EV_EXITLP);                         // L2 stays
      queue_event(EV_LINKSET, 1'b1);
      queue_event(EV_EQSTART);
      queue_event(EV_PRESET, 1'b0, '0, 4'd7);
      queue_event(EV_PRESET, 1'b0, '0, 4'd15);        // out of range preset dropped
      queue_event(EV_TS2);
      repeat (3) queue_event(EV_EQADV);
      queue_event(EV_TS2);                            // no effect once done
      queue_event(EV_PRSNT, 1'b0);
      queue_event(EV_SWITCH, 1'b0, 3'd2);             // left pending across the mode change
      wait_drained();

      write_llp(1'b0);
      @(posedge clock);
      queue_event(EV_TICK, 1'b0, '0, '0, 1'b0);       // pending switch finishes, no pulse
      queue_event(EV_SWITCH, 1'b0, 3'd6);             // immediate switch
      queue_event(EV_LINKSET, 1'b0, 3'd6);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         write_llp(p[0] ? 1'b0 : 1'b1);
         @(posedge clock);
         queue_random_items(410);
         wait_drained();
      end

      repeat (5) @(negedge clock);
      $display("covered %0d events over both link-layer modes, %0d status words checked",
               items_accepted, words_checked);
      $display("switch requests %0d, completions %0d, insertions %0d, removals %0d",
               n_requests, n_completes, m_insertions, m_removals);
      if (err_count == 0 && status_queue.size() == 0) begin
         $display("tb_pcie_link_training_controller: done, clean");
      end else begin
         $display("tb_pcie_link_training_controller: done, errors");
      end
      $finish;
   end

endmodule
